// ===== rtl/core/rms_level_smoother_defines.svh =====
// Assertion macros shared by the RMS level smoother RTL.
// Pure text macros; no dependencies.
`ifndef RMS_LEVEL_SMOOTHER_DEFINES_SVH
`define RMS_LEVEL_SMOOTHER_DEFINES_SVH

// Same-cycle implication, masked during reset
`define RLS_ASSERT_NOW(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("rms_level_smoother: same-cycle check failed");

// Next-cycle implication, masked during reset
`define RLS_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("rms_level_smoother: next-cycle check failed");

`endif

// ===== rtl/core/rls_pkg.sv =====
// Shared types and constants for the RMS level smoother.
// No dependencies.
`timescale 1ns / 1ps

package rls_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int SQUARE_W   = 31;
   localparam int SUM_W      = 44;
   localparam int COUNT_W    = 14;
   localparam int LEVEL_W    = 16;
   localparam int MEAN_W     = 32;
   localparam int DIVISOR_W  = 16;
   localparam int BLEND_W    = 23;
   localparam int RECIP_W    = 18;
   localparam int PROD_W     = BLEND_W + RECIP_W;
   localparam int RECIP_SHIFT = 24;

   localparam logic [LEVEL_W-1:0] CEILING_RESET = 16'd11141;
   localparam logic [LEVEL_W-1:0] FULL_SCALE    = 16'hFFFF;

   // Smoothing: (93 * old + 7 * new + 50) / 100
   localparam logic [BLEND_W-1:0] BLEND_OLD  = 23'd93;
   localparam logic [BLEND_W-1:0] BLEND_NEW  = 23'd7;
   localparam logic [BLEND_W-1:0] BLEND_BIAS = 23'd50;
   localparam logic [BLEND_W-1:0] BLEND_DIV  = 23'd100;
   // floor(2^24 / 100); estimate is low by at most one for blend sums below 2^23
   localparam logic [RECIP_W-1:0] RECIP_100  = 18'd167772;

   // Status of an iterative arithmetic unit
   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

   // Level update sequencer
   typedef enum logic [10:0] {
      S_IDLE       = 11'b00000000001,
      S_MEAN       = 11'b00000000010,
      S_MEAN_WAIT  = 11'b00000000100,
      S_ROOT       = 11'b00000001000,
      S_ROOT_WAIT  = 11'b00000010000,
      S_BLEND      = 11'b00000100000,
      S_RECIP      = 11'b00001000000,
      S_CORR       = 11'b00010000000,
      S_SCALE      = 11'b00100000000,
      S_SCALE_WAIT = 11'b01000000000,
      S_EMIT       = 11'b10000000000
   } seq_state_type;

endpackage

// ===== rtl/core/rls_square_lane.sv =====
// One channel lane: magnitude of a Q1.15 sample, squared and registered.
// Depends on rls_pkg.
`timescale 1ns / 1ps

module rls_square_lane (
   input  logic                              clock,
   input  logic                              load,
   input  logic signed [rls_pkg::SAMPLE_W-1:0] sample,
   output logic        [rls_pkg::SQUARE_W-1:0] square
);

   logic [rls_pkg::SAMPLE_W-1:0]   mag;
   logic [2*rls_pkg::SAMPLE_W-1:0] prod;
   logic [rls_pkg::SQUARE_W-1:0]   square_ff;
   logic [rls_pkg::SQUARE_W-1:0]   square_in;

   // -32768 wraps to 0x8000, which is the right unsigned magnitude
   assign mag       = sample[rls_pkg::SAMPLE_W-1] ? (~sample + 1'b1) : sample;
   assign prod      = mag * mag;
   assign square_in = prod[rls_pkg::SQUARE_W-1:0];

   always_ff @(posedge clock) begin
      if (load) begin
         square_ff <= square_in;
      end
   end

   assign square = square_ff;

endmodule

// ===== rtl/core/rls_divider.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on rls_pkg.
`timescale 1ns / 1ps

module rls_divider (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [rls_pkg::SUM_W-1:0]       dividend,
   input  logic [rls_pkg::DIVISOR_W-1:0]   divisor,
   output logic [rls_pkg::SUM_W-1:0]       quotient,
   output rls_pkg::unit_status_type        status
);

   localparam int STEP_W = $clog2(rls_pkg::SUM_W + 1);
   localparam logic [STEP_W-1:0] STEPS = STEP_W'(rls_pkg::SUM_W);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [STEP_W-1:0]             step_ff, step_in;
   logic [rls_pkg::SUM_W-1:0]     quot_ff, quot_in;
   logic [rls_pkg::DIVISOR_W-1:0] rem_ff, rem_in;
   logic [rls_pkg::DIVISOR_W-1:0] dsr_ff, dsr_in;
   logic [rls_pkg::DIVISOR_W:0]   rem_shift;
   logic [rls_pkg::DIVISOR_W:0]   rem_diff;
   logic                          fits;

   // Trial subtract of the shifted remainder
   assign rem_shift = {rem_ff, quot_ff[rls_pkg::SUM_W-1]};
   assign rem_diff  = rem_shift - {1'b0, dsr_ff};
   assign fits      = rem_shift >= {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEPS;
         quot_in = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         quot_in = {quot_ff[rls_pkg::SUM_W-2:0], fits};
         rem_in  = fits ? rem_diff[rls_pkg::DIVISOR_W-1:0]
                        : rem_shift[rls_pkg::DIVISOR_W-1:0];
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
   end

   assign quotient    = quot_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// ===== rtl/core/rls_sqrt.sv =====
// Digit-by-digit integer square root, one root bit per cycle.
// Depends on rls_pkg.
`timescale 1ns / 1ps

module rls_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [rls_pkg::MEAN_W-1:0]    operand,
   output logic [rls_pkg::LEVEL_W-1:0]   root,
   output rls_pkg::unit_status_type      status
);

   localparam int ROOT_W = rls_pkg::MEAN_W / 2;
   localparam int STEP_W = $clog2(ROOT_W + 1);
   localparam logic [STEP_W-1:0] STEPS = STEP_W'(ROOT_W);

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [STEP_W-1:0]          step_ff, step_in;
   logic [rls_pkg::MEAN_W-1:0] x_ff, x_in;
   logic [ROOT_W:0]            rem_ff, rem_in;
   logic [ROOT_W-1:0]          root_ff, root_in;
   logic [ROOT_W+2:0]          rem_shift;
   logic [ROOT_W+2:0]          trial;
   logic [ROOT_W+2:0]          rem_diff;
   logic                       fits;

   // Bring down the next bit pair, trial = 4 * root + 1
   assign rem_shift = {rem_ff, x_ff[rls_pkg::MEAN_W-1 -: 2]};
   assign trial     = {1'b0, root_ff, 2'b01};
   assign rem_diff  = rem_shift - trial;
   assign fits      = rem_shift >= trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      x_in    = x_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEPS;
         x_in    = operand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         x_in    = {x_ff[rls_pkg::MEAN_W-3:0], 2'b00};
         rem_in  = fits ? rem_diff[ROOT_W:0] : rem_shift[ROOT_W:0];
         root_in = {root_ff[ROOT_W-2:0], fits};
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign root        = rls_pkg::LEVEL_W'(root_ff);
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// ===== rtl/core/rms_level_smoother.sv =====
// A last-of-buffer frame runs the sequencer before rsp_tvalid rises: two 44-step
// divider passes (mean square, then scaled level), the 16-step square root and
// the sequencing states between them.
// Throughput: one frame per cycle between buffer ends; after a buffer-end frame
// the next frame is taken once the sequencer is back in idle at the earliest, later
// while a result waits. Reset (synchronous): sum, count, level clear; ceiling to 11141.
`timescale 1ns / 1ps
`include "rms_level_smoother_defines.svh"

module rms_level_smoother #(
   parameter int MAX_FRAMES = 512
) (
   input  logic        clock,
   input  logic        reset,
   // Frame input
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] left_sample, [31:16] right_sample
   input  logic        req_tlast,   // last_in_buffer
   // Level output
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [15:0] smoothed_level, [31:16] scaled_level
   // Ceiling register
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   localparam logic [rls_pkg::COUNT_W-1:0] COUNT_LIMIT =
      rls_pkg::COUNT_W'(2 * MAX_FRAMES);
   localparam int RECIP_LO = rls_pkg::RECIP_SHIFT;

   rls_pkg::seq_state_type state_ff, state_in;

   logic                            req_take;
   logic                            lane_vld_ff, lane_vld_in;
   logic                            lane_last_ff, lane_last_in;
   logic [rls_pkg::SQUARE_W-1:0]    square_l, square_r;

   logic [rls_pkg::SUM_W-1:0]       sum_ff, sum_in;
   logic [rls_pkg::COUNT_W-1:0]     count_ff, count_in;
   logic [rls_pkg::LEVEL_W-1:0]     ceiling_ff, ceiling_in;
   logic [rls_pkg::LEVEL_W-1:0]     level_ff, level_in;

   logic                            cnt_zero_ff, cnt_zero_in;
   logic [rls_pkg::MEAN_W-1:0]      mean_ff, mean_in;
   logic [rls_pkg::LEVEL_W-1:0]     rms_ff, rms_in;
   logic [rls_pkg::BLEND_W-1:0]     blend_ff, blend_in;
   logic [rls_pkg::PROD_W-1:0]      prod_ff, prod_in;
   logic [rls_pkg::LEVEL_W-1:0]     scaled_ff, scaled_in;

   logic                            rsp_vld_ff, rsp_vld_in;
   logic [31:0]                     rsp_data_ff, rsp_data_in;

   logic                            div_start;
   logic [rls_pkg::SUM_W-1:0]       div_dividend;
   logic [rls_pkg::DIVISOR_W-1:0]   div_divisor;
   logic [rls_pkg::SUM_W-1:0]       div_quot;
   rls_pkg::unit_status_type        div_stat;

   logic                            root_start;
   logic [rls_pkg::LEVEL_W-1:0]     root_val;
   rls_pkg::unit_status_type        root_stat;

   logic [rls_pkg::PROD_W-RECIP_LO-1:0] q_est;
   logic [rls_pkg::BLEND_W-1:0]     q_rem;
   logic [rls_pkg::PROD_W-RECIP_LO:0] q_fix;
   logic                            rsp_free;

   // Input handshake: hold off while a buffer end is pending or running
   assign req_tready = (state_ff == rls_pkg::S_IDLE) && !(lane_vld_ff && lane_last_ff);
   assign req_take   = req_tvalid && req_tready;

   // Channel lanes
   rls_square_lane u_lane_l (
      .clock  (clock),
      .load   (req_take),
      .sample (req_tdata[15:0]),
      .square (square_l)
   );

   rls_square_lane u_lane_r (
      .clock  (clock),
      .load   (req_take),
      .sample (req_tdata[31:16]),
      .square (square_r)
   );

   // Shared divider: mean square, then scaled level
   assign div_start    = (state_ff == rls_pkg::S_MEAN) || (state_ff == rls_pkg::S_SCALE);
   assign div_dividend = (state_ff == rls_pkg::S_MEAN) ? sum_ff
                       : {{(rls_pkg::SUM_W-2*rls_pkg::LEVEL_W){1'b0}}, level_ff,
                          {rls_pkg::LEVEL_W{1'b0}}};
   assign div_divisor  = (state_ff == rls_pkg::S_MEAN)
                       ? rls_pkg::DIVISOR_W'(count_ff) : ceiling_ff;

   rls_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quot),
      .status   (div_stat)
   );

   assign root_start = (state_ff == rls_pkg::S_ROOT);

   rls_sqrt u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (root_start),
      .operand (mean_ff),
      .root    (root_val),
      .status  (root_stat)
   );

   // Divide-by-100 correction: estimate is exact or one low
   assign q_est = prod_ff[rls_pkg::PROD_W-1:RECIP_LO];
   assign q_rem = blend_ff - rls_pkg::BLEND_W'(q_est) * rls_pkg::BLEND_DIV;
   assign q_fix = {1'b0, q_est} + ((q_rem >= rls_pkg::BLEND_DIV) ? 1'b1 : 1'b0);

   assign rsp_free = !rsp_vld_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      lane_vld_in  = req_take;
      lane_last_in = req_take ? req_tlast : lane_last_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      ceiling_in   = csr_wr_en ? csr_wr_data : ceiling_ff;
      level_in     = level_ff;
      cnt_zero_in  = cnt_zero_ff;
      mean_in      = mean_ff;
      rms_in       = rms_ff;
      blend_in     = blend_ff;
      prod_in      = prod_ff;
      scaled_in    = scaled_ff;
      rsp_vld_in   = rsp_vld_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      // Merge stage: fold both lane squares into the running sum while count is below its limit
      if (lane_vld_ff && (count_ff < COUNT_LIMIT)) begin
         sum_in   = sum_ff + rls_pkg::SUM_W'(square_l) + rls_pkg::SUM_W'(square_r);
         count_in = count_ff + rls_pkg::COUNT_W'(2);
      end

      unique case (state_ff)
         rls_pkg::S_IDLE: begin
            if (lane_vld_ff && lane_last_ff) begin
               state_in = rls_pkg::S_MEAN;
            end
         end
         rls_pkg::S_MEAN: begin
            // divider has taken sum and count; start the next buffer afresh
            cnt_zero_in = (count_ff == '0);
            sum_in      = '0;
            count_in    = '0;
            state_in    = rls_pkg::S_MEAN_WAIT;
         end
         rls_pkg::S_MEAN_WAIT: begin
            if (div_stat.done) begin
               mean_in  = cnt_zero_ff ? '0 : div_quot[rls_pkg::MEAN_W-1:0];
               state_in = rls_pkg::S_ROOT;
            end
         end
         rls_pkg::S_ROOT: begin
            state_in = rls_pkg::S_ROOT_WAIT;
         end
         rls_pkg::S_ROOT_WAIT: begin
            if (root_stat.done) begin
               rms_in   = root_val;
               state_in = rls_pkg::S_BLEND;
            end
         end
         rls_pkg::S_BLEND: begin
            blend_in = rls_pkg::BLEND_W'(level_ff) * rls_pkg::BLEND_OLD
                     + rls_pkg::BLEND_W'(rms_ff) * rls_pkg::BLEND_NEW
                     + rls_pkg::BLEND_BIAS;
            state_in = rls_pkg::S_RECIP;
         end
         rls_pkg::S_RECIP: begin
            prod_in  = rls_pkg::PROD_W'(blend_ff) * rls_pkg::PROD_W'(rls_pkg::RECIP_100);
            state_in = rls_pkg::S_CORR;
         end
         rls_pkg::S_CORR: begin
            level_in = (q_fix > rls_pkg::FULL_SCALE) ? rls_pkg::FULL_SCALE
                                                     : rls_pkg::LEVEL_W'(q_fix);
            state_in = rls_pkg::S_SCALE;
         end
         rls_pkg::S_SCALE: begin
            state_in = rls_pkg::S_SCALE_WAIT;
         end
         rls_pkg::S_SCALE_WAIT: begin
            if (div_stat.done) begin
               if ((ceiling_ff == '0) ||
                   (div_quot[rls_pkg::SUM_W-1:rls_pkg::LEVEL_W] != '0)) begin
                  scaled_in = rls_pkg::FULL_SCALE;
               end else begin
                  scaled_in = div_quot[rls_pkg::LEVEL_W-1:0];
               end
               state_in = rls_pkg::S_EMIT;
            end
         end
         rls_pkg::S_EMIT: begin
            if (rsp_free) begin
               rsp_vld_in  = 1'b1;
               rsp_data_in = {scaled_ff, level_ff};
               state_in    = rls_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = rls_pkg::S_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rls_pkg::S_IDLE;
         lane_vld_ff  <= 1'b0;
         lane_last_ff <= 1'b0;
         sum_ff       <= '0;
         count_ff     <= '0;
         ceiling_ff   <= rls_pkg::CEILING_RESET;
         level_ff     <= '0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lane_vld_ff  <= lane_vld_in;
         lane_last_ff <= lane_last_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         ceiling_ff   <= ceiling_in;
         level_ff     <= level_in;
         rsp_vld_ff   <= rsp_vld_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      cnt_zero_ff <= cnt_zero_in;
      mean_ff     <= mean_in;
      rms_ff      <= rms_in;
      blend_ff    <= blend_in;
      prod_ff     <= prod_in;
      scaled_ff   <= scaled_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Checks
   `RLS_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, (count_ff <= COUNT_LIMIT) && !count_ff[0])
   `RLS_ASSERT_NEXT(a_clear_on_mean, clock, reset, state_ff == rls_pkg::S_MEAN, (count_ff == '0) && (sum_ff == '0))
   `RLS_ASSERT_NOW(a_rsp_from_emit, clock, reset, $rose(rsp_vld_ff), $past(state_ff == rls_pkg::S_EMIT))
   `RLS_ASSERT_NOW(a_one_unit_busy, clock, reset, 1'b1, !(div_stat.busy && root_stat.busy))

endmodule
